// ===== sv/sbfr_pkg.sv =====
// Shared types and constants for the serial radio frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbfr_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int POS_W       = 5;
  localparam int LANE_W      = 4;
  localparam int CHAN_BYTES  = 10;
  localparam int RAW_W       = CHAN_BYTES * 8;
  localparam int CHAN_W      = 11;
  localparam int OUT_W       = 13;
  localparam int NUM_CHANS   = 7;
  localparam int COUNT_W     = 16;
  localparam int OFFSET_W    = 12;

  localparam logic [POS_W-1:0] FRAME_LEN      = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] FIRST_LOAD_POS = 5'd11;
  localparam logic [POS_W-1:0] LAST_LOAD_POS  = 5'd20;
  localparam logic [POS_W-1:0] READ_LEAD      = 5'd10;
  localparam logic [POS_W-1:0] FLAG_ADDR      = 5'd23;

  localparam logic [7:0] SYNC_BYTE = 8'h0F;
  localparam int LOST_BIT     = 2;
  localparam int FAILSAFE_BIT = 3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_GAP    = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [COUNT_W-1:0]  GAP_RESET    = 16'd8;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd1980;

  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } ram_req_t;

  // Says what the word coming back from the frame RAM is for.
  typedef struct packed {
    logic              load;
    logic [LANE_W-1:0] lane;
    logic              emit;
  } rd_tag_t;

endpackage

`default_nettype wire

// ===== sv/sbfr_frame_ram.sv =====
// Frame byte store: one write port and one read port, read data registered.
// Depends on sbfr_pkg.
`default_nettype none

module sbfr_frame_ram
  import sbfr_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbfr_cfg_regs.sv =====
// APB-style register file holding the sync gap and channel offset.
// Depends on sbfr_pkg.
`default_nettype none

module sbfr_cfg_regs
  import sbfr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [COUNT_W-1:0]       gap_ticks,
  output logic [OFFSET_W-1:0]      channel_offset
);

  logic wr;
  logic idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks      <= GAP_RESET;
      channel_offset <= OFFSET_RESET;
    end else if (wr) begin
      case (idx)
        REG_GAP:    gap_ticks      <= pwdata[COUNT_W-1:0];
        REG_OFFSET: channel_offset <= pwdata[OFFSET_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAP:    prdata = {16'd0, gap_ticks};
      REG_OFFSET: prdata = {20'd0, channel_offset};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sbfr_sync_ctrl.sv =====
// Frame sync, byte position and heartbeat tracking; drives the frame RAM.
// Depends on sbfr_pkg.
`default_nettype none

module sbfr_sync_ctrl
  import sbfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [COUNT_W-1:0] gap_ticks,
  input  wire logic               out_valid,
  output ram_req_t                req,
  output rd_tag_t                 tag
);

  logic [POS_W-1:0]   byte_pos, byte_pos_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic [COUNT_W-1:0] frame_start_time, frame_start_time_next;
  logic               frame_emitted, frame_emitted_next;
  rd_tag_t            tag_next;

  logic               acc, is_byte, restart, store, emit, busy;
  logic [COUNT_W-1:0] elapsed;
  logic [POS_W-1:0]   pos_eff, lane_pos;
  logic               emitted_eff;

  // Hold the input whenever all frame bytes are stored, the frame is not yet
  // reported and the result path is still occupied.
  assign busy     = out_valid || tag.emit;
  assign in_stall = (byte_pos == FRAME_LEN) && !frame_emitted && busy;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    is_byte     = (cmd == CMD_BYTE);
    elapsed     = tick_count - frame_start_time;
    restart     = is_byte && (rx_byte == SYNC_BYTE) && (elapsed >= gap_ticks);
    pos_eff     = restart ? '0 : byte_pos;
    emitted_eff = restart ? 1'b0 : frame_emitted;
    store       = is_byte && (pos_eff < FRAME_LEN);
    emit        = is_byte && !store && !emitted_eff;
    lane_pos    = pos_eff - FIRST_LOAD_POS;

    req.wr_en   = acc && store;
    req.wr_addr = pos_eff;
    req.wr_data = rx_byte;
    req.rd_en   = 1'b0;
    req.rd_addr = pos_eff - READ_LEAD;

    tag_next = '0;
    tag_next.lane = lane_pos[LANE_W-1:0];
    if (acc && store && (pos_eff >= FIRST_LOAD_POS) && (pos_eff <= LAST_LOAD_POS)) begin
      req.rd_en     = 1'b1;
      tag_next.load = 1'b1;
    end else if (acc && emit) begin
      req.rd_en     = 1'b1;
      req.rd_addr   = FLAG_ADDR;
      tag_next.emit = 1'b1;
    end

    tick_count_next       = tick_count;
    frame_start_time_next = frame_start_time;
    byte_pos_next         = byte_pos;
    frame_emitted_next    = frame_emitted;
    if (acc) begin
      if (!is_byte) begin
        tick_count_next = tick_count + 1'b1;
      end else begin
        if (restart) begin
          frame_start_time_next = tick_count;
        end
        byte_pos_next      = store ? pos_eff + 1'b1 : pos_eff;
        frame_emitted_next = emit ? 1'b1 : emitted_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos         <= '0;
      tick_count       <= '0;
      frame_start_time <= '0;
      frame_emitted    <= 1'b0;
      tag              <= '0;
    end else begin
      byte_pos         <= byte_pos_next;
      tick_count       <= tick_count_next;
      frame_start_time <= frame_start_time_next;
      frame_emitted    <= frame_emitted_next;
      tag              <= tag_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbfr_chan_unpack.sv =====
// Channel byte collection, offset adders, status counters and output register.
// Depends on sbfr_pkg.
`default_nettype none

module sbfr_chan_unpack
  import sbfr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rd_tag_t             tag,
  input  wire logic [7:0]          rd_data,
  input  wire logic [OFFSET_W-1:0] channel_offset,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [OUT_W-1:0]         chan [NUM_CHANS],
  output logic                     link_ok,
  output logic [COUNT_W-1:0]       lost_frames,
  output logic [COUNT_W-1:0]       failsafe_frames
);

  logic [RAW_W-1:0] raw;

  // Channel bytes 1..10 arrive in order; place each in its lane.
  always_ff @(posedge clk) begin
    if (tag.load) begin
      for (int i = 0; i < CHAN_BYTES; i++) begin
        if (tag.lane == LANE_W'(i)) begin
          raw[i*8 +: 8] <= rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag.emit) begin
      for (int k = 0; k < NUM_CHANS; k++) begin
        chan[k] <= {2'b00, raw[k*CHAN_W +: CHAN_W]} + {1'b0, channel_offset};
      end
      link_ok <= !rd_data[FAILSAFE_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      lost_frames     <= '0;
      failsafe_frames <= '0;
    end else if (tag.emit) begin
      out_valid       <= 1'b1;
      lost_frames     <= lost_frames + COUNT_W'(rd_data[LOST_BIT]);
      failsafe_frames <= failsafe_frames + COUNT_W'(rd_data[FAILSAFE_BIT]);
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbus_frame_receiver_decoder.sv =====
// Top level of the serial radio frame receiver and channel decoder.
// Depends on sbfr_pkg, sbfr_cfg_regs, sbfr_frame_ram, sbfr_sync_ctrl, sbfr_chan_unpack.
//
// Usage:
//   Input channel (in_valid/in_stall, cmd, rx_byte): one word per cycle while not
//   stalled, either a received byte (cmd 0) or a heartbeat tick (cmd 1). A word is
//   taken at each edge where in_valid is high and in_stall is low.
//   Output channel (out_valid/out_stall): one decoded frame per word, seven
//   offset channels, link_ok and the lost/failsafe counters.
//   Throughput: one input word every cycle while in_stall is low. The frame RAM
//   has one write and one read port; channel bytes are read back while later
//   bytes of the frame are still arriving, so the completing byte only needs the
//   flag byte read. The completing byte starts a registered read of the flag
//   byte, and the result built from it is registered in the output register.
//   in_stall rises only when a frame is ready to complete while the previous
//   result is still waiting in the output register; it drops once taken.
//   Reset (rst, synchronous): clears position, tick and start-time state, the
//   counters and both registers to their defaults. The frame RAM is not
//   cleared; a frame is only reported after all its bytes were written.
//   Registers (APB, write only while idle): 0x0 gap_ticks, 0x4 channel_offset.
`default_nettype none

module sbus_frame_receiver_decoder
  import sbfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  rx_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [12:0]      chan_one,
  output logic [12:0]      chan_two,
  output logic [12:0]      chan_three,
  output logic [12:0]      chan_four,
  output logic [12:0]      chan_five,
  output logic [12:0]      chan_six,
  output logic [12:0]      chan_seven,
  output logic             link_ok,
  output logic [15:0]      lost_frames,
  output logic [15:0]      failsafe_frames,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [COUNT_W-1:0]  gap_ticks;
  logic [OFFSET_W-1:0] channel_offset;
  ram_req_t            req;
  rd_tag_t             tag;
  logic [7:0]          rd_data;
  logic [OUT_W-1:0]    chan [NUM_CHANS];

  sbfr_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .gap_ticks      (gap_ticks),
    .channel_offset (channel_offset)
  );

  // Sync detection and position tracking; issues RAM writes and read-backs.
  sbfr_sync_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .gap_ticks (gap_ticks),
    .out_valid (out_valid),
    .req       (req),
    .tag       (tag)
  );

  sbfr_frame_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Collect channel bytes, add the offset and hold the result word.
  sbfr_chan_unpack u_unpack (
    .clk             (clk),
    .rst             (rst),
    .tag             (tag),
    .rd_data         (rd_data),
    .channel_offset  (channel_offset),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .chan            (chan),
    .link_ok         (link_ok),
    .lost_frames     (lost_frames),
    .failsafe_frames (failsafe_frames)
  );

  assign chan_one   = chan[0];
  assign chan_two   = chan[1];
  assign chan_three = chan[2];
  assign chan_four  = chan[3];
  assign chan_five  = chan[4];
  assign chan_six   = chan[5];
  assign chan_seven = chan[6];

endmodule

`default_nettype wire

// ===== sv/sbfr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module sbfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        cmd,
  input wire logic [7:0]  rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [12:0] chan_one,
  input wire logic [12:0] chan_two,
  input wire logic [12:0] chan_three,
  input wire logic [12:0] chan_four,
  input wire logic [12:0] chan_five,
  input wire logic [12:0] chan_six,
  input wire logic [12:0] chan_seven,
  input wire logic        link_ok,
  input wire logic [15:0] lost_frames,
  input wire logic [15:0] failsafe_frames,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // A waiting result stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Frames are many bytes apart, so a taken result is never followed at once.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("two results in consecutive cycles");

  // Holding input with an empty output means a result is in flight and appears in the next cycle.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_valid |=> out_valid)
    else $error("input held without a pending result");

  // Failsafe count steps exactly when a new result reports radio off.
  a_failsafe_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $rose(out_valid) |->
      failsafe_frames == $past(failsafe_frames) + {15'd0, !link_ok})
    else $error("failsafe count out of step with link_ok");

  // Counters move only when a new result is shown.
  a_counters_stable: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$rose(out_valid) |->
      $stable(lost_frames) && $stable(failsafe_frames))
    else $error("status counter changed without a result");

endmodule

bind sbus_frame_receiver_decoder sbfr_checker u_sbfr_checker (.*);

`default_nettype wire

// ===== dv/sbus_frame_receiver_decoder_tb.sv =====
// Testbench for the serial radio frame receiver and channel decoder.
// Depends on sbfr_pkg and sbus_frame_receiver_decoder; holds its own frame decoder
// model and checks every decoded frame against it, field by field.

module sbus_frame_receiver_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfr_pkg::*;

  // Receiver holds off this long once, after this many words have gone in.
  localparam int LONG_HOLD_AT     = 500;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OUT_W-1:0]   chan_one;
    logic [OUT_W-1:0]   chan_two;
    logic [OUT_W-1:0]   chan_three;
    logic [OUT_W-1:0]   chan_four;
    logic [OUT_W-1:0]   chan_five;
    logic [OUT_W-1:0]   chan_six;
    logic [OUT_W-1:0]   chan_seven;
    logic               link_ok;
    logic [COUNT_W-1:0] lost_frames;
    logic [COUNT_W-1:0] failsafe_frames;
  } frame_result_t;

  // One entry of the stimulus list; a drain entry is never sent, it makes the
  // sender wait until every owed frame result has come out.
  typedef struct packed {
    logic       drain;
    logic       cmd;
    logic [7:0] data;
  } rx_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        cmd       = CMD_BYTE;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] chan_one, chan_two, chan_three, chan_four, chan_five, chan_six, chan_seven;
  logic        link_ok;
  logic [15:0] lost_frames, failsafe_frames;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sbus_frame_receiver_decoder dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chan_one        (chan_one),
    .chan_two        (chan_two),
    .chan_three      (chan_three),
    .chan_four       (chan_four),
    .chan_five       (chan_five),
    .chan_six        (chan_six),
    .chan_seven      (chan_seven),
    .link_ok         (link_ok),
    .lost_frames     (lost_frames),
    .failsafe_frames (failsafe_frames),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: its own copy of the registers and of the frame state.
  // Registers change only from the stimulus process, and only while idle.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]  gap_cfg    = GAP_RESET;
  logic [OFFSET_W-1:0] offset_cfg = OFFSET_RESET;

  logic [7:0]         frame_buf [FRAME_BYTES];
  logic [POS_W-1:0]   buf_pos    = '0;
  logic [COUNT_W-1:0] tick_cnt   = '0;
  logic [COUNT_W-1:0] start_tick = '0;
  logic               frame_done = 1'b0;
  logic [COUNT_W-1:0] lost_cnt   = '0;
  logic [COUNT_W-1:0] fs_cnt     = '0;

  frame_result_t frames_due [$];

  function automatic logic [OUT_W-1:0] with_offset(logic [CHAN_W-1:0] raw);
    return OUT_W'(raw) + OUT_W'(offset_cfg);
  endfunction

  // Advance the model by one accepted word; queue the frame result it causes.
  function automatic void decode_word(logic kind, logic [7:0] b);
    logic [COUNT_W-1:0] elapsed;
    logic [7:0]         flags;
    frame_result_t      r;
    if (kind == CMD_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      return;
    end
    // elapsed wraps at 16 bits, like the counter itself
    elapsed = tick_cnt - start_tick;
    if (elapsed >= gap_cfg && b == SYNC_BYTE) begin
      buf_pos    = '0;
      start_tick = tick_cnt;
      frame_done = 1'b0;
    end
    if (buf_pos < FRAME_LEN) begin
      frame_buf[buf_pos] = b;
      buf_pos = buf_pos + 1'b1;
      return;
    end
    // trailing bytes after the completing one are dropped
    if (frame_done) return;
    frame_done = 1'b1;
    r.chan_one   = with_offset({frame_buf[2][2:0], frame_buf[1]});
    r.chan_two   = with_offset({frame_buf[3][5:0], frame_buf[2][7:3]});
    r.chan_three = with_offset({frame_buf[5][0], frame_buf[4], frame_buf[3][7:6]});
    r.chan_four  = with_offset({frame_buf[6][3:0], frame_buf[5][7:1]});
    r.chan_five  = with_offset({frame_buf[7][6:0], frame_buf[6][7:4]});
    r.chan_six   = with_offset({frame_buf[9][1:0], frame_buf[8], frame_buf[7][7]});
    r.chan_seven = with_offset({frame_buf[10][4:0], frame_buf[9][7:2]});
    flags = frame_buf[FLAG_ADDR];
    if (flags[LOST_BIT]) lost_cnt = lost_cnt + 1'b1;
    if (flags[FAILSAFE_BIT]) fs_cnt = fs_cnt + 1'b1;
    r.link_ok         = !flags[FAILSAFE_BIT];
    r.lost_frames     = lost_cnt;
    r.failsafe_frames = fs_cnt;
    frames_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: take accepted input words into the model, then check any frame
  // result taken at the same edge against the oldest one owed.
  // ---------------------------------------------------------------------------
  int            words_taken = 0;
  int            mismatches  = 0;
  frame_result_t due_frame;

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : word_monitor
    if (!rst) begin
      if (in_valid && !in_stall) begin
        decode_word(cmd, rx_byte);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame result with none owed: chan_one %0d lost %0d failsafe %0d",
                     chan_one, lost_frames, failsafe_frames);
        end else begin
          due_frame = frames_due.pop_front();
          check_field("chan_one", due_frame.chan_one, chan_one);
          check_field("chan_two", due_frame.chan_two, chan_two);
          check_field("chan_three", due_frame.chan_three, chan_three);
          check_field("chan_four", due_frame.chan_four, chan_four);
          check_field("chan_five", due_frame.chan_five, chan_five);
          check_field("chan_six", due_frame.chan_six, chan_six);
          check_field("chan_seven", due_frame.chan_seven, chan_seven);
          check_field("link_ok", due_frame.link_ok, link_ok);
          check_field("lost_frames", due_frame.lost_frames, lost_frames);
          check_field("failsafe_frames", due_frame.failsafe_frames, failsafe_frames);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: walk the stimulus list at the falling edge. A word on the bus is
  // held until the monitor has counted it in; only then move to the next one.
  // ---------------------------------------------------------------------------
  rx_word_t word_q [$];
  int       next_word   = 0;
  int       words_sent  = 0;
  int       src_gap     = 0;
  bit       src_idle_on = 1'b1;

  always @(negedge clk) begin : word_driver
    if (!in_valid || words_taken == words_sent) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        in_valid <= 1'b0;
      end else if (next_word >= word_q.size()) begin
        in_valid <= 1'b0;
      end else if (word_q[next_word].drain) begin
        // pause the sender until every owed frame result has come out
        in_valid <= 1'b0;
        if (frames_due.size() == 0) next_word = next_word + 1;
      end else if (src_idle_on && $urandom_range(7) == 0) begin
        src_gap = $urandom_range(19, 1) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        cmd      <= word_q[next_word].cmd;
        rx_byte  <= word_q[next_word].data;
        next_word  = next_word + 1;
        words_sent = words_sent + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: random bursts, plus one long hold-off so that the output
  // register stays full and the block has to stall its input.
  // ---------------------------------------------------------------------------
  int sink_gap     = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;
  bit sink_idle_on = 1'b1;

  always @(negedge clk) begin : stall_driver
    if (!hold_used && words_taken >= LONG_HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap = sink_gap - 1;
      out_stall <= 1'b1;
    end else if (sink_idle_on && $urandom_range(7) == 0) begin
      sink_gap = $urandom_range(19, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  int words_queued = 0;

  task automatic push_word(logic kind, logic [7:0] b);
    word_q.push_back('{1'b0, kind, b});
    words_queued++;
  endtask

  task automatic push_drain();
    word_q.push_back('{1'b1, CMD_BYTE, 8'h00});
  endtask

  // Tick words carry a random, ignored byte.
  task automatic push_ticks(int n);
    repeat (n) push_word(CMD_TICK, 8'($urandom));
  endtask

  function automatic logic [7:0] rand_byte(bit allow_sync);
    logic [7:0] b;
    case ($urandom_range(15))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = SYNC_BYTE;
      default: b = 8'($urandom);
    endcase
    if (!allow_sync && b == SYNC_BYTE) b = b ^ 8'h10;
    return b;
  endfunction

  // Frame bytes after the sync, now and then with ticks in between.
  task automatic push_body(int n, bit allow_sync, bit tick_noise);
    repeat (n) begin
      if (tick_noise && $urandom_range(9) == 0) push_ticks($urandom_range(3, 1));
      push_word(CMD_BYTE, rand_byte(allow_sync));
    end
  endtask

  // Lead-in ticks, sync, 23 frame bytes, then one to three trailing bytes.
  task automatic push_frame(int lead, bit allow_sync, bit tick_noise);
    push_ticks(lead);
    push_word(CMD_BYTE, SYNC_BYTE);
    push_body(FRAME_BYTES - 1, allow_sync, tick_noise);
    push_body($urandom_range(3, 1), 1'b1, tick_noise);
  endtask

  // Mostly complete frames with random content; the rest early syncs, cut-off
  // frames, loose noise and the odd pause of the sender.
  task automatic push_random(int n, int gap);
    int first;
    int pick;
    first = words_queued;
    while (words_queued - first < n) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        push_frame(gap + $urandom_range(3), $urandom_range(3) == 0, $urandom_range(1));
      end else if (pick < 78) begin
        push_frame(gap == 0 ? 0 : $urandom_range(gap - 1), 1'b1, 1'b0);
      end else if (pick < 88) begin
        push_ticks(gap + $urandom_range(2));
        push_word(CMD_BYTE, SYNC_BYTE);
        push_body($urandom_range(22, 1), 1'b1, 1'b1);
      end else if (pick < 97) begin
        repeat ($urandom_range(6, 1)) push_word(1'($urandom), rand_byte(1'b1));
      end else begin
        push_drain();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes: setup cycle, then access cycle; the write lands at the
  // edge where pready is seen high. Upper data bits are random and must be
  // ignored by the block.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_GAP) gap_cfg = value[COUNT_W-1:0];
    else offset_cfg = value[OFFSET_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] gap, logic [11:0] offset);
    write_reg(REG_GAP, {16'($urandom), gap});
    write_reg(REG_OFFSET, {20'($urandom), offset});
  endtask

  // Wait until every queued word is in and every owed result out, then let
  // the block settle, since a word may still be in flight with no result.
  task automatic wait_idle();
    while (next_word < word_q.size() || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int gap_d;
    int guard;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers. A sync straight after reset comes too early and is
    // stored as plain data, as is an early sync inside the partial frame.
    push_word(CMD_BYTE, SYNC_BYTE);
    push_word(CMD_BYTE, 8'hAA);
    push_word(CMD_BYTE, 8'h55);
    push_word(CMD_BYTE, SYNC_BYTE);
    // Gap reached: restart mid-frame, all-ones frame with both flags set.
    push_ticks(8);
    push_word(CMD_BYTE, SYNC_BYTE);
    repeat (FRAME_BYTES - 1) push_word(CMD_BYTE, 8'hFF);
    push_word(CMD_BYTE, 8'h12);
    push_word(CMD_BYTE, 8'h34);
    // All-zero frame, radio on; then an early sync among the trailing bytes.
    push_ticks(8);
    push_word(CMD_BYTE, SYNC_BYTE);
    repeat (FRAME_BYTES - 1) push_word(CMD_BYTE, 8'h00);
    push_word(CMD_BYTE, 8'h00);
    push_ticks(2);
    push_word(CMD_BYTE, SYNC_BYTE);
    push_word(CMD_BYTE, 8'hFF);
    // Six more ticks make the gap; frame with only the frame-lost flag.
    push_ticks(6);
    push_word(CMD_BYTE, SYNC_BYTE);
    push_body(FRAME_BYTES - 2, 1'b0, 1'b0);
    push_word(CMD_BYTE, 8'h04);
    push_word(CMD_BYTE, 8'hC3);
    push_random(300, 8);
    wait_idle();

    // Zero gap: every sync restarts; largest offset. Long hold-off lands here.
    set_config(16'd0, 12'd4095);
    push_random(350, 0);
    // Last word a sync with no tick after it, so the next phase counts from it.
    push_word(CMD_BYTE, SYNC_BYTE);
    wait_idle();

    // Long gap, zero offset. One tick short the sync is data; after the
    // full gap it starts a frame.
    src_idle_on = 1'b0;
    set_config(16'd40, 12'd0);
    push_ticks(39);
    push_word(CMD_BYTE, SYNC_BYTE);
    push_ticks(1);
    push_frame(0, 1'b0, 1'b0);
    wait_idle();
    src_idle_on = 1'b1;

    // Middling gap and random offset, with a forced pause of the sender.
    gap_d = $urandom_range(20, 1);
    set_config(16'(gap_d), 12'($urandom));
    push_random(200, gap_d);
    push_drain();
    push_random(150, gap_d);
    wait_idle();

    // Closing stretch at full rate on both sides.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    gap_d = $urandom_range(12, 1);
    set_config(16'(gap_d), 12'd2047);
    push_random(250, gap_d);

    guard = 0;
    while ((next_word < word_q.size() || in_valid || frames_due.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0)
      $display("%0d frame results never arrived", frames_due.size());
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin : watchdog
    #4ms;
    $display("timeout waiting on the block");
    $display("== FAIL ==");
    $finish;
  end

endmodule
